/* hw/rtl/sofsw_pkg.sv */
// Package for the symbol-order block: sizes, status codes, state types and
// the beat record passed from the front end to the back end. No dependencies.
package sofsw_pkg;
    localparam int ALPHABET  = 32;
    localparam int MAX_WORD  = 64;
    localparam int SYM_W     = 5;
    localparam int POS_W     = 7;   // holds 0..MAX_WORD
    localparam int ADDR_W    = 6;   // indexes MAX_WORD entries
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_PREFIX = 2'd1;
    localparam logic [1:0] ST_CYCLE  = 2'd2;
    localparam logic [1:0] ST_LONG   = 2'd3;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             word_end;
        logic             list_end;
    } t_beat;

    typedef enum logic [2:0] {
        S_RUN, S_SEED, S_POP, S_SCAN, S_EMIT, S_FAIL, S_CLEAR
    } t_state;
endpackage

/* hw/rtl/sofsw_front.sv */
// Front end: accepts input beats and holds them in a short queue toward the
// back end. Depends on sofsw_pkg.
module sofsw_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sofsw_pkg::t_beat      i_beat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sofsw_pkg::t_beat      o_beat
);
    import sofsw_pkg::*;

    t_beat             r_mem [QDEPTH];
    logic [QPTR_W:0]   r_wr, r_rd;
    logic              w_full, w_push, w_pop;

    assign w_full  = (r_wr[QPTR_W] != r_rd[QPTR_W]) && (r_wr[QPTR_W-1:0] == r_rd[QPTR_W-1:0]);
    assign o_ready = !w_full;
    assign o_valid = (r_wr != r_rd);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_beat  = r_mem[r_rd[QPTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr[QPTR_W-1:0]] <= i_beat;
        end
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
        end
    end
endmodule

/* hw/rtl/sofsw_back.sv */
// Back end: compares words, records edges and runs the closing sort with a
// result register toward the output. Depends on sofsw_pkg.
module sofsw_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sofsw_pkg::t_beat      i_beat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [sofsw_pkg::SYM_W-1:0] o_sym,
    output logic [1:0]            o_status,
    output logic                  o_last
);
    import sofsw_pkg::*;

    // Word store: two buffers, written and read in clocked blocks.
    logic [SYM_W-1:0]  r_store [2*MAX_WORD];
    logic [SYM_W-1:0]  r_prev_sym;
    logic              r_phase;              // 0: read old symbol, 1: act on it

    logic [POS_W-1:0]  r_prev_len, r_pos;
    logic              r_buf, r_diff, r_have;
    logic [1:0]        r_fail;
    logic [ALPHABET-1:0] r_present;
    logic [ALPHABET-1:0] r_edge [ALPHABET];
    logic [SYM_W-1:0]  r_deg [ALPHABET];
    logic [SYM_W-1:0]  r_queue [ALPHABET];
    logic [SYM_W:0]    r_head, r_tail, r_total;
    logic [SYM_W-1:0]  r_u, r_v;
    logic              r_vdone;

    t_state            r_state, n_state;
    logic              r_ovalid;
    logic [SYM_W-1:0]  r_osym;
    logic [1:0]        r_ostat;
    logic              r_olast;

    logic              w_take, w_long, w_cmp, w_end;
    logic [ADDR_W-1:0] w_addr;
    logic              w_ofree, w_load, w_lastsym;

    assign w_ofree   = !r_ovalid || i_ready;
    assign w_take    = i_valid && o_ready;
    assign w_long    = (r_pos >= POS_W'(MAX_WORD));
    assign w_addr    = r_pos[ADDR_W-1:0];
    assign w_cmp     = r_have && !r_diff && (r_pos < r_prev_len) && !w_long;
    assign w_end     = i_beat.word_end || i_beat.list_end;
    assign w_lastsym = (r_v == SYM_W'(r_total - 1'b1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (w_take && i_beat.list_end) n_state = S_SEED;
            end
            S_SEED: begin
                if (r_fail != ST_OK) n_state = S_FAIL;
                else if (r_vdone) n_state = S_POP;
            end
            S_POP: begin
                if (r_head != r_tail) n_state = S_SCAN;
                else if (r_head == r_total) n_state = S_EMIT;
                else n_state = S_FAIL;
            end
            S_SCAN: begin
                if (r_vdone) n_state = S_POP;
            end
            S_EMIT: begin
                if (w_ofree && w_lastsym) n_state = S_CLEAR;
            end
            S_FAIL: begin
                if (w_ofree) n_state = S_CLEAR;
            end
            S_CLEAR: begin
                if (r_vdone) n_state = S_RUN;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            S_RUN:          o_ready = r_phase;
            S_EMIT, S_FAIL: w_load  = w_ofree;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_phase <= 1'b0; r_prev_len <= '0; r_pos <= '0;
            r_buf <= 1'b0; r_diff <= 1'b0; r_have <= 1'b0; r_fail <= ST_OK;
            r_present <= '0; r_ovalid <= 1'b0; r_v <= '0; r_vdone <= 1'b0;
            r_head <= '0; r_tail <= '0; r_total <= '0;
        end else begin
            if (w_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_RUN: begin
                    if (!r_phase) begin
                        if (i_valid) begin
                            r_prev_sym <= r_store[{~r_buf, w_addr}];
                            r_phase <= 1'b1;
                        end
                    end else if (w_take) begin
                        r_phase <= 1'b0;
                        r_present[i_beat.symbol] <= 1'b1;
                        if (w_long) begin
                            if (r_fail == ST_OK) r_fail <= ST_LONG;
                        end else begin
                            r_store[{r_buf, w_addr}] <= i_beat.symbol;
                            if (w_cmp && r_prev_sym != i_beat.symbol) begin
                                if (!r_edge[r_prev_sym][i_beat.symbol]) begin
                                    r_edge[r_prev_sym][i_beat.symbol] <= 1'b1;
                                    r_deg[i_beat.symbol] <= r_deg[i_beat.symbol] + 1'b1;
                                end
                                r_diff <= 1'b1;
                            end
                        end
                        if (w_end) begin
                            if (r_have && !(r_diff || (w_cmp && r_prev_sym != i_beat.symbol))
                                && r_prev_len > (w_long ? r_pos : r_pos + 1'b1)
                                && r_fail == ST_OK && !(w_long))
                                r_fail <= ST_PREFIX;
                            r_prev_len <= w_long ? r_pos : r_pos + 1'b1;
                            r_buf <= ~r_buf; r_pos <= '0; r_diff <= 1'b0; r_have <= 1'b1;
                        end else if (!w_long) begin
                            r_pos <= r_pos + 1'b1;
                        end
                        if (i_beat.list_end) begin
                            r_v <= '0; r_vdone <= 1'b0; r_head <= '0; r_tail <= '0;
                            r_total <= '0;
                        end
                    end
                end
                S_SEED: begin
                    if (r_present[r_v]) begin
                        r_total <= r_total + 1'b1;
                        if (r_deg[r_v] == '0) begin
                            r_queue[r_tail[SYM_W-1:0]] <= r_v;
                            r_tail <= r_tail + 1'b1;
                        end
                    end
                    if (r_vdone) begin
                        r_v <= '0; r_vdone <= 1'b0;
                    end else begin
                        r_v <= r_v + 1'b1;
                        r_vdone <= (r_v == SYM_W'(ALPHABET-2));
                    end
                end
                S_POP: begin
                    r_v <= '0; r_vdone <= 1'b0;
                    if (r_head != r_tail) begin
                        r_u <= r_queue[r_head[SYM_W-1:0]];
                    end else if (r_head != r_total) begin
                        // Symbols left with predecessors: the graph has a cycle.
                        r_fail <= ST_CYCLE;
                    end
                end
                S_SCAN: begin
                    if (r_edge[r_u][r_v] && r_deg[r_v] != '0) begin
                        r_deg[r_v] <= r_deg[r_v] - 1'b1;
                        if (r_deg[r_v] == SYM_W'(1)) begin
                            r_queue[r_tail[SYM_W-1:0]] <= r_v;
                            r_tail <= r_tail + 1'b1;
                        end
                    end
                    if (r_vdone) begin
                        r_head <= r_head + 1'b1; r_v <= '0; r_vdone <= 1'b0;
                    end else begin
                        r_v <= r_v + 1'b1;
                        r_vdone <= (r_v == SYM_W'(ALPHABET-2));
                    end
                end
                S_EMIT: begin
                    // Sort done; queue now holds the order in slots 0..head-1.
                    if (w_ofree) begin
                        r_osym <= r_queue[r_v];
                        r_ostat <= ST_OK;
                        r_olast <= w_lastsym;
                        if (w_lastsym) begin
                            r_v <= '0; r_vdone <= 1'b0;
                        end else begin
                            r_v <= r_v + 1'b1;
                        end
                    end
                end
                S_FAIL: begin
                    if (w_ofree) begin
                        r_osym <= '0; r_ostat <= r_fail; r_olast <= 1'b1;
                        r_v <= '0; r_vdone <= 1'b0;
                    end
                end
                S_CLEAR: begin
                    r_edge[r_v] <= '0; r_deg[r_v] <= '0;
                    if (r_vdone) begin
                        r_v <= '0; r_vdone <= 1'b0; r_present <= '0; r_fail <= ST_OK;
                        r_prev_len <= '0; r_pos <= '0; r_buf <= 1'b0; r_diff <= 1'b0;
                        r_have <= 1'b0; r_phase <= 1'b0; r_total <= '0;
                    end else begin
                        r_v <= r_v + 1'b1;
                        r_vdone <= (r_v == SYM_W'(ALPHABET-2));
                    end
                end
                default: ;
            endcase
            r_state <= n_state;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_sym    = r_osym;
    assign o_status = r_ostat;
    assign o_last   = r_olast;
endmodule

/* hw/rtl/symbol_order_from_sorted_words.sv */
// Top level of the symbol-order block: front queue and back end.
// Depends on sofsw_pkg, sofsw_front and sofsw_back.
//
// Usage: a sorted word list streams in on the s_axis channel, one symbol
// per beat, tlast marking the end of the list and tuser the end of a word.
// For each symbol the back end first reads the matching symbol of the
// previous word from the word store, then compares it with the new one and
// records an edge. A four-entry queue parts the input from the back end.
// On the list's last beat the back end seeds the sort, then scans the edges
// of each symbol it takes from the ready queue until it finds the queue
// empty, then emits the order (one beat per cycle while the receiver takes
// them) or a single failure beat, and clears the edge matrix. The back end
// takes no symbols during the sort and clearing; the queue still accepts up
// to four beats before tready drops. A stalled receiver holds the output
// register and stops the back end. After reset the back end first runs the
// clearing pass before it takes symbols.
module symbol_order_from_sorted_words (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [4:0] symbol, zero fill above
    input  logic       s_axis_tuser,   // word_end
    input  logic       s_axis_tlast,   // list_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [4:0] order_symbol, [6:5] status, zero fill
    output logic       m_axis_tlast    // last
);
    import sofsw_pkg::*;

    t_beat            w_in, w_q;
    logic             w_qv, w_qr;
    logic [SYM_W-1:0] w_sym;
    logic [1:0]       w_stat;

    assign w_in = '{symbol: s_axis_tdata[SYM_W-1:0], word_end: s_axis_tuser,
                    list_end: s_axis_tlast};

    sofsw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_beat(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_beat(w_q)
    );

    sofsw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_beat(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_sym(w_sym), .o_status(w_stat), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_stat, w_sym};
endmodule

/* hw/rtl/sofsw_checker.sv */
// Port-level checker for the symbol-order block, bound to the top level.
// Depends on sofsw_pkg and the top level's ports.
module sofsw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    import sofsw_pkg::*;

    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6:5] != ST_OK |-> m_axis_tlast)
        else $error("failure beat without last");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6:5] != ST_OK |-> m_axis_tdata[4:0] == 5'd0)
        else $error("failure beat with symbol");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[7])
        else $error("pad bit set");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled beat changed");
endmodule

bind symbol_order_from_sorted_words sofsw_checker u_checker (.*);
